// File: rtl/greedy_balanced_partitioner_assert.svh
// ----------------------------------------------------------------------------
// Greedy balanced partitioner assertion macros
// Shorthand for clocked assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BALANCED_PARTITIONER_ASSERT_SVH
`define GREEDY_BALANCED_PARTITIONER_ASSERT_SVH

// Check a property on every rising edge outside reset
`define GBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define GBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/gbp_pkg.sv
// ----------------------------------------------------------------------------
// Greedy balanced partitioner package
// Payload types, configuration layout, register indices and engine states.
// ----------------------------------------------------------------------------
package gbp_pkg;

  // Input transaction: entry count of one index
  typedef struct packed {
    logic [23:0] entry_count;
    logic        end_of_list;
  } in_item_t;

  // Output transaction: one block boundary
  typedef struct packed {
    logic [4:0]  boundary_position;
    logic [20:0] boundary_value;
    logic        last_boundary;
  } out_item_t;

  // Live configuration
  typedef struct packed {
    logic [30:0] target_load;
    logic [4:0]  num_blocks;
    logic [20:0] total_indices;
  } cfg_t;

  // Register indices
  localparam logic [1:0] CFG_TARGET_LOAD   = 2'd0;
  localparam logic [1:0] CFG_NUM_BLOCKS    = 2'd1;
  localparam logic [1:0] CFG_TOTAL_INDICES = 2'd2;

  // Register reset values
  localparam logic [30:0] TARGET_LOAD_RST   = 31'd1;
  localparam logic [4:0]  NUM_BLOCKS_RST    = 5'd13;
  localparam logic [20:0] TOTAL_INDICES_RST = 21'd1048576;

  // Hard cap on boundaries per run and the smallest block count
  localparam int unsigned RESULT_CAP = 16;
  localparam logic [4:0]  MIN_BLOCKS = 5'd2;

  // Queue depths
  localparam int unsigned IN_DEPTH  = 2;
  localparam int unsigned OUT_DEPTH = 4;

  // Engine sequencer
  typedef enum logic [1:0] {
    ST_ADD,
    ST_CMP,
    ST_FIN
  } state_e;

endpackage

// File: rtl/gbp_fifo.sv
// ----------------------------------------------------------------------------
// Greedy balanced partitioner queue
// Small register queue with push/full and pop/empty, head shown combinationally.
// ----------------------------------------------------------------------------
module gbp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/gbp_engine.sv
// ----------------------------------------------------------------------------
// Greedy balanced partitioner engine
// Takes counts from the input queue, decides cuts and pushes boundaries.
// ----------------------------------------------------------------------------
module gbp_engine #(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbp_pkg::cfg_t     cfg_i,
  input  gbp_pkg::in_item_t in_item_i,
  input  logic              in_empty_i,
  output logic              in_pop_o,
  output gbp_pkg::out_item_t out_item_o,
  input  logic              out_full_i,
  output logic              out_push_o
);

  localparam int unsigned CapInt = (MAX_BLOCKS < gbp_pkg::RESULT_CAP) ?
                                   MAX_BLOCKS : gbp_pkg::RESULT_CAP;
  localparam logic [4:0] Cap = 5'(CapInt);

  gbp_pkg::state_e state_q, state_d;

  logic [31:0] run_q, run_d;
  logic [31:0] best_q, best_d;
  logic [31:0] load_q, load_d;
  logic [20:0] idx_q, idx_d;
  logic [4:0]  be_q, be_d;
  logic        fin_q, fin_d;
  logic        have_q, have_d;
  logic [23:0] cnt_q, cnt_d;
  logic        eol_q, eol_d;

  logic [4:0]  lim;
  logic [23:0] cur_cnt;
  logic        cur_eol;
  logic [32:0] sum;
  logic [31:0] sat_load;
  logic [31:0] tgt;
  logic [31:0] trial_dist;
  logic [20:0] idx_inc;

  // Clamp the block count
  always_comb begin
    if (cfg_i.num_blocks < gbp_pkg::MIN_BLOCKS) begin
      lim = gbp_pkg::MIN_BLOCKS;
    end else if (cfg_i.num_blocks > Cap) begin
      lim = Cap;
    end else begin
      lim = cfg_i.num_blocks;
    end
  end

  // Current item: held copy on a retry, queue head on the first attempt
  assign cur_cnt = have_q ? cnt_q : in_item_i.entry_count;
  assign cur_eol = have_q ? eol_q : in_item_i.end_of_list;

  // Saturating load sum
  assign sum      = {1'b0, run_q} + {9'b0, cur_cnt};
  assign sat_load = sum[32] ? '1 : sum[31:0];

  // Distance of the trial load from the target
  assign tgt        = {1'b0, cfg_i.target_load};
  assign trial_dist = (load_q > tgt) ? (load_q - tgt) : (tgt - load_q);
  assign idx_inc    = idx_q + 21'd1;

  // Sequence one attempt at a time
  always_comb begin
    state_d    = state_q;
    run_d      = run_q;
    best_d     = best_q;
    load_d     = load_q;
    idx_d      = idx_q;
    be_d       = be_q;
    fin_d      = fin_q;
    have_d     = have_q;
    cnt_d      = cnt_q;
    eol_d      = eol_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    out_item_o = '0;

    case (state_q)
      gbp_pkg::ST_ADD: begin
        if (have_q || !in_empty_i) begin
          if (!have_q) begin
            in_pop_o = 1'b1;
            have_d   = 1'b1;
            cnt_d    = in_item_i.entry_count;
            eol_d    = in_item_i.end_of_list;
          end
          if (fin_q) begin
            // drop counts until the list ends, then re-arm
            have_d = 1'b0;
            if (cur_eol) begin
              run_d  = '0;
              best_d = tgt;
              idx_d  = '0;
              be_d   = 5'd1;
              fin_d  = 1'b0;
            end
          end else if (be_q >= lim) begin
            state_d = gbp_pkg::ST_FIN;
          end else begin
            load_d  = sat_load;
            state_d = gbp_pkg::ST_CMP;
          end
        end
      end

      gbp_pkg::ST_CMP: begin
        if (trial_dist <= best_q) begin
          // take the count into the block
          run_d  = load_q;
          best_d = trial_dist;
          idx_d  = idx_inc;
          if (eol_q || (idx_inc >= cfg_i.total_indices)) begin
            state_d = gbp_pkg::ST_FIN;
          end else begin
            have_d  = 1'b0;
            state_d = gbp_pkg::ST_ADD;
          end
        end else if (!out_full_i) begin
          // cut here, restart empty and retry the same count
          out_push_o                   = 1'b1;
          out_item_o.boundary_position = be_q;
          out_item_o.boundary_value    = idx_q;
          out_item_o.last_boundary     = 1'b0;
          be_d                         = be_q + 5'd1;
          run_d                        = '0;
          best_d                       = tgt;
          state_d                      = gbp_pkg::ST_ADD;
        end
      end

      gbp_pkg::ST_FIN: begin
        if (!out_full_i) begin
          out_push_o                   = 1'b1;
          out_item_o.boundary_position = be_q;
          out_item_o.boundary_value    = cfg_i.total_indices;
          out_item_o.last_boundary     = 1'b1;
          have_d                       = 1'b0;
          state_d                      = gbp_pkg::ST_ADD;
          if (eol_q) begin
            run_d  = '0;
            best_d = tgt;
            idx_d  = '0;
            be_d   = 5'd1;
            fin_d  = 1'b0;
          end else begin
            fin_d = 1'b1;
          end
        end
      end

      default: begin
        state_d = gbp_pkg::ST_ADD;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbp_pkg::ST_ADD;
    end else begin
      state_q <= state_d;
    end
  end

  // Run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      best_q <= {1'b0, gbp_pkg::TARGET_LOAD_RST};
      idx_q  <= '0;
      be_q   <= 5'd1;
      fin_q  <= 1'b0;
      have_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      best_q <= best_d;
      idx_q  <= idx_d;
      be_q   <= be_d;
      fin_q  <= fin_d;
      have_q <= have_d;
    end
  end

  // Held item and trial load
  always_ff @(posedge clk_i) begin
    load_q <= load_d;
    cnt_q  <= cnt_d;
    eol_q  <= eol_d;
  end

endmodule

// File: rtl/greedy_balanced_partitioner.sv
// ----------------------------------------------------------------------------
// Greedy balanced partitioner
// Cuts a stream of per-index entry counts into contiguous blocks near a target.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_item_i and raise push; the count is taken on a
//   rising edge with push high and full low. Raise end_of_list on the last index.
//   Result queue side: while empty is low, out_item_o shows the oldest boundary;
//   pop high with empty low takes it. The last boundary of a run has
//   last_boundary set and equals total_indices.
//   Configuration: cfg_valid_i with cfg_index_i and cfg_data_i; cfg_ready_o is
//   always high. Write only while the block is idle.
//   Sequencing: each attempt at a count is a saturating add, then a distance
//   compare, through the single engine; each cut before a count that fits
//   adds another attempt, and the final boundary takes a step of its own.
//   Reset: queues empty, registers return to defaults, a fresh run begins.
//   Stalls: a full result queue holds the engine, the input queue then fills
//   and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module greedy_balanced_partitioner #(
  parameter int unsigned MAX_BLOCKS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbp_pkg::in_item_t  in_item_i,
  input  logic               push,
  output logic               full,
  output gbp_pkg::out_item_t out_item_o,
  output logic               empty,
  input  logic               pop,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i
);

  gbp_pkg::cfg_t      cfg_q;
  gbp_pkg::in_item_t  head_item;
  gbp_pkg::out_item_t eng_item;
  logic               in_empty, in_pop;
  logic               out_full, out_push;
  logic [$bits(gbp_pkg::in_item_t)-1:0]  in_rdata;
  logic [$bits(gbp_pkg::out_item_t)-1:0] out_rdata;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_load   <= gbp_pkg::TARGET_LOAD_RST;
      cfg_q.num_blocks    <= gbp_pkg::NUM_BLOCKS_RST;
      cfg_q.total_indices <= gbp_pkg::TOTAL_INDICES_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gbp_pkg::CFG_TARGET_LOAD:   cfg_q.target_load   <= cfg_data_i;
        gbp_pkg::CFG_NUM_BLOCKS:    cfg_q.num_blocks    <= cfg_data_i[4:0];
        gbp_pkg::CFG_TOTAL_INDICES: cfg_q.total_indices <= cfg_data_i[20:0];
        default: ;
      endcase
    end
  end

  // Front: input queue
  gbp_fifo #(
    .WIDTH ($bits(gbp_pkg::in_item_t)),
    .DEPTH (gbp_pkg::IN_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_item_i),
    .full_o  (full),
    .pop_i   (in_pop),
    .rdata_o (in_rdata),
    .empty_o (in_empty)
  );

  assign head_item = gbp_pkg::in_item_t'(in_rdata);

  // Back: partitioning engine
  gbp_engine #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_item_i  (head_item),
    .in_empty_i (in_empty),
    .in_pop_o   (in_pop),
    .out_item_o (eng_item),
    .out_full_i (out_full),
    .out_push_o (out_push)
  );

  // Result queue
  gbp_fifo #(
    .WIDTH ($bits(gbp_pkg::out_item_t)),
    .DEPTH (gbp_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (eng_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_item_o = gbp_pkg::out_item_t'(out_rdata);

endmodule

// File: rtl/gbp_checker.sv
// ----------------------------------------------------------------------------
// Greedy balanced partitioner port checker
// Watches the result queue port for reset, hold and boundary numbering.
// ----------------------------------------------------------------------------
`include "greedy_balanced_partitioner_assert.svh"

module gbp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input gbp_pkg::out_item_t out_item_o,
  input logic               empty,
  input logic               pop
);

  // No result is offered while reset is held
  `GBP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result shown during reset")

  // A waiting result holds until taken
  `GBP_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_item_o)), "result changed")

  // Inside a run boundaries are numbered one after another
  `GBP_ASSERT(a_pos_step, (pop && !empty && !out_item_o.last_boundary) ##1 !empty |-> out_item_o.boundary_position == $past(out_item_o.boundary_position) + 5'd1, "boundary numbering broken")

  // A new run starts at boundary one
  `GBP_ASSERT(a_pos_restart, (pop && !empty && out_item_o.last_boundary) ##1 !empty |-> out_item_o.boundary_position == 5'd1, "run does not restart at one")

endmodule

bind greedy_balanced_partitioner gbp_checker u_gbp_checker (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Greedy balanced partitioner testbench
// Streams entry counts through the partitioner under random push and pop
// stalls. A predictor of the cutting rules forecasts every
// boundary, and each popped boundary is compared field by field against the
// oldest forecast. A short table of hand-picked counts and register writes
// runs first, followed by randomised lists under many register settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BLOCKS    = 16;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PRINT_LIMIT   = 20;
  // Index with no register behind it; writes to it must change nothing
  localparam logic [1:0]  CFG_SPARE     = 2'd3;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // How a table row is checked: by the predictor, or by a typed result
  typedef enum logic [1:0] {
    WANT_MODEL,
    WANT_NONE,
    WANT_ONE
  } want_e;

  typedef struct packed {
    row_kind_e          kind;
    want_e              want;
    logic [1:0]         reg_idx;
    logic [30:0]        reg_val;
    logic [23:0]        count;
    logic               eol;
    gbp_pkg::out_item_t res;
  } stim_row_t;

  localparam gbp_pkg::out_item_t NO_RES = '0;

  // Directed stimulus: reset defaults, extreme counts and registers,
  // out-of-range block counts, list end by index count, ignored inputs
  // after the final boundary, and a block count lowered mid-run
  localparam int unsigned PLAN_ROWS = 26;
  localparam stim_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_ITEM, WANT_NONE,  gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd0, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_NONE,  gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd1, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_ONE,   gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd1, 1'b0,
      '{5'd1, 21'd2, 1'b0}},
    '{ROW_ITEM, WANT_ONE,   gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd0, 1'b1,
      '{5'd2, 21'd1048576, 1'b1}},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd0, 1'b0, NO_RES},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_NUM_BLOCKS,    31'd0, 24'd0, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_MODEL, gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'hFFFFFF, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_NONE,  gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd5, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_NONE,  gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd7, 1'b1, NO_RES},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_TARGET_LOAD,   31'h7FFFFFFF, 24'd0, 1'b0, NO_RES},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_NUM_BLOCKS,    31'd31, 24'd0, 1'b0, NO_RES},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_TOTAL_INDICES, 31'd3, 24'd0, 1'b0, NO_RES},
    '{ROW_CFG,  WANT_MODEL, CFG_SPARE,                  31'h7FFFFFFF, 24'd0, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_MODEL, gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'hFFFFFF, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_MODEL, gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'hFFFFFF, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_MODEL, gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'hFFFFFF, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_NONE,  gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd0, 1'b1, NO_RES},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_TARGET_LOAD,   31'd1, 24'd0, 1'b0, NO_RES},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_NUM_BLOCKS,    31'd16, 24'd0, 1'b0, NO_RES},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_TOTAL_INDICES, 31'd1048576, 24'd0, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_NONE,  gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd1, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_ONE,   gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd1, 1'b0,
      '{5'd1, 21'd1, 1'b0}},
    '{ROW_ITEM, WANT_ONE,   gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd1, 1'b0,
      '{5'd2, 21'd2, 1'b0}},
    '{ROW_CFG,  WANT_MODEL, gbp_pkg::CFG_NUM_BLOCKS,    31'd2, 24'd0, 1'b0, NO_RES},
    '{ROW_ITEM, WANT_ONE,   gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd9, 1'b0,
      '{5'd3, 21'd1048576, 1'b1}},
    '{ROW_ITEM, WANT_NONE,  gbp_pkg::CFG_TARGET_LOAD,   31'd0, 24'd0, 1'b1, NO_RES}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  gbp_pkg::in_item_t  in_item_i;
  logic               push;
  logic               full;
  gbp_pkg::out_item_t out_item_o;
  logic               empty;
  logic               pop = 1'b0;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [30:0]        cfg_data_i;

  // Predictor copy of the registers
  logic [30:0] cfg_target;
  logic [4:0]  cfg_blocks;
  logic [20:0] cfg_total;

  // Predictor copy of the partitioning state
  logic [31:0] load_acc;
  logic [31:0] best_dist;
  logic [20:0] idx_count;
  logic [4:0]  cut_count;
  logic        run_done;

  gbp_pkg::out_item_t fresh_q[$];
  gbp_pkg::out_item_t boundary_q[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  greedy_balanced_partitioner #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .push       (push),
    .full       (full),
    .out_item_o (out_item_o),
    .empty      (empty),
    .pop        (pop),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Free-running clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: cycle limit reached with %0d boundaries outstanding",
               boundary_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drain the result side, stalling at random outside calm stretches
  always @(posedge clk_i) begin
    pop <= rst_ni && (calm || ($urandom_range(99) >= 20));
  end

  // Compare each boundary that the coming edge will take
  always @(negedge clk_i) begin
    if (rst_ni && pop && !empty) check_boundary(out_item_o);
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("ERROR: %0t %s", $time, msg);
  endtask

  task automatic check_boundary(input gbp_pkg::out_item_t got);
    gbp_pkg::out_item_t want;
    if (boundary_q.size() == 0) begin
      note_mismatch($sformatf("unexpected boundary pos %0d val %0d last %0d",
                              got.boundary_position, got.boundary_value,
                              got.last_boundary));
      return;
    end
    want = boundary_q.pop_front();
    if (got.boundary_position !== want.boundary_position)
      note_mismatch($sformatf("boundary_position %0d, want %0d",
                              got.boundary_position, want.boundary_position));
    if (got.boundary_value !== want.boundary_value)
      note_mismatch($sformatf("boundary_value %0d, want %0d (pos %0d)",
                              got.boundary_value, want.boundary_value,
                              want.boundary_position));
    if (got.last_boundary !== want.last_boundary)
      note_mismatch($sformatf("last_boundary %0d, want %0d (pos %0d)",
                              got.last_boundary, want.last_boundary,
                              want.boundary_position));
  endtask

  // ---------------------------------------------------------------------
  // Partitioning predictor
  // ---------------------------------------------------------------------

  function automatic int unsigned block_cap();
    int unsigned cap;
    cap = cfg_blocks;
    if (cap < gbp_pkg::MIN_BLOCKS) cap = gbp_pkg::MIN_BLOCKS;
    if (cap > MAX_BLOCKS) cap = MAX_BLOCKS;
    if (cap > gbp_pkg::RESULT_CAP) cap = gbp_pkg::RESULT_CAP;
    return cap;
  endfunction

  task automatic restart_run();
    load_acc  = '0;
    best_dist = {1'b0, cfg_target};
    idx_count = '0;
    cut_count = 5'd1;
    run_done  = 1'b0;
  endtask

  // Emit the final boundary; re-arm at once only on list end
  task automatic close_run(input logic eol);
    gbp_pkg::out_item_t b;
    b.boundary_position = cut_count;
    b.boundary_value    = cfg_total;
    b.last_boundary     = 1'b1;
    fresh_q.push_back(b);
    if (eol) restart_run();
    else run_done = 1'b1;
  endtask

  task automatic apply_reg(input logic [1:0] idx, input logic [30:0] val);
    case (idx)
      gbp_pkg::CFG_TARGET_LOAD:   cfg_target = val;
      gbp_pkg::CFG_NUM_BLOCKS:    cfg_blocks = val[4:0];
      gbp_pkg::CFG_TOTAL_INDICES: cfg_total  = val[20:0];
      default: ;
    endcase
  endtask

  // Work out the boundaries that one entry count causes into fresh_q
  task automatic partition_step(input gbp_pkg::in_item_t it);
    logic [32:0]        sum;
    logic [31:0]        load;
    logic [31:0]        trial_dist;
    logic [31:0]        tgt;
    int unsigned        cap;
    gbp_pkg::out_item_t b;
    fresh_q.delete();
    cap = block_cap();
    if (run_done) begin
      if (it.end_of_list) restart_run();
      return;
    end
    forever begin
      if (cut_count >= cap) begin
        close_run(it.end_of_list);
        return;
      end
      tgt        = {1'b0, cfg_target};
      sum        = {1'b0, load_acc} + {9'd0, it.entry_count};
      load       = sum[32] ? '1 : sum[31:0];
      trial_dist = (load > tgt) ? load - tgt : tgt - load;
      if (trial_dist <= best_dist) begin
        load_acc  = load;
        best_dist = trial_dist;
        idx_count = idx_count + 21'd1;
        break;
      end
      // Cut before this index, restart the block and retry the count
      b.boundary_position = cut_count;
      b.boundary_value    = idx_count;
      b.last_boundary     = 1'b0;
      fresh_q.push_back(b);
      cut_count = cut_count + 5'd1;
      load_acc  = '0;
      best_dist = tgt;
    end
    if (it.end_of_list || idx_count >= cfg_total) close_run(it.end_of_list);
  endtask

  task automatic queue_forecast();
    foreach (fresh_q[k]) boundary_q.push_back(fresh_q[k]);
  endtask

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one count after a random gap and hold it until the queue takes it
  task automatic push_item(input gbp_pkg::in_item_t it);
    bit taken;
    while (!calm && $urandom_range(99) < 20) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    in_item_i <= it;
    push      <= 1'b1;
    forever begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
      if (taken) break;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
      if (taken) break;
    end
    apply_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the sender until every forecast boundary is out and the engine is idle
  task automatic settle();
    push <= 1'b0;
    while (boundary_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  initial begin
    gbp_pkg::in_item_t it;
    int unsigned       items_done;
    int unsigned       phase;
    int unsigned       phase_len;
    int unsigned       phase_items;
    int unsigned       list_len;
    int unsigned       cmax;
    int unsigned       sel;
    logic [30:0]       tgt;
    logic [4:0]        nb;
    logic [20:0]       ti;
    bit                noisy;
    bit                armed;

    rst_ni      = 1'b0;
    in_item_i   = '0;
    push        = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = gbp_pkg::CFG_TARGET_LOAD;
    cfg_data_i  = '0;
    cfg_target  = gbp_pkg::TARGET_LOAD_RST;
    cfg_blocks  = gbp_pkg::NUM_BLOCKS_RST;
    cfg_total   = gbp_pkg::TOTAL_INDICES_RST;
    restart_run();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        settle();
        write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
      end else begin
        it.entry_count = PLAN[r].count;
        it.end_of_list = PLAN[r].eol;
        push_item(it);
        partition_step(it);
        case (PLAN[r].want)
          WANT_NONE: begin
            if (fresh_q.size() != 0)
              note_mismatch($sformatf("row %0d: predictor gives %0d boundaries",
                                      r, fresh_q.size()));
          end
          WANT_ONE: begin
            if (fresh_q.size() != 1 || fresh_q[0] != PLAN[r].res)
              note_mismatch($sformatf("row %0d: predictor disagrees with table", r));
            boundary_q.push_back(PLAN[r].res);
          end
          default: queue_forecast();
        endcase
      end
    end

    // Random phases, each under fresh register settings
    items_done = 0;
    phase      = 0;
    while (items_done < RANDOM_ITEMS) begin
      settle();

      sel = $urandom_range(0, 7);
      case (sel)
        0:       tgt = '0;
        1:       tgt = 31'h7FFFFFFF;
        2, 3:    tgt = 31'($urandom_range(1, 64));
        4, 5:    tgt = 31'($urandom_range(65, 100000));
        default: tgt = 31'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) nb = 5'($urandom_range(0, 31));
      else nb = 5'($urandom_range(2, 16));
      sel = $urandom_range(0, 7);
      case (sel)
        4:       ti = '0;
        5:       ti = 21'd1;
        6:       ti = 21'd1048576;
        7:       ti = 21'($urandom);
        default: ti = 21'($urandom_range(1, 48));
      endcase
      // Upper data bits beyond the block and index fields carry junk that must be dropped
      write_reg(gbp_pkg::CFG_TARGET_LOAD, tgt);
      write_reg(gbp_pkg::CFG_NUM_BLOCKS, {26'($urandom), nb});
      write_reg(gbp_pkg::CFG_TOTAL_INDICES, {10'($urandom), ti});
      if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE, 31'($urandom));

      // Scale counts so that a block holds a few of them
      if (tgt == 0) begin
        cmax = 16;
      end else begin
        cmax = (32'(tgt) * 2) / $urandom_range(1, 6);
        if (cmax > 32'hFFFFFF) cmax = 32'hFFFFFF;
      end

      calm      = (phase == 3);
      phase_len = calm ? 120 : $urandom_range(15, 40);
      phase_items = 0;
      while (phase_items < phase_len) begin
        list_len = $urandom_range(1, 12);
        for (int j = 0; j < list_len; j++) begin
          noisy = ($urandom_range(99) < 20);
          if (noisy) begin
            it.entry_count = 24'($urandom_range(0, 24'hFFFFFF));
            it.end_of_list = ($urandom_range(0, 3) == 0);
          end else begin
            it.entry_count = 24'($urandom_range(0, cmax));
            it.end_of_list = (j == list_len - 1);
          end
          push_item(it);
          armed = !run_done;
          partition_step(it);
          queue_forecast();
          if (armed) begin
            items_done++;
            phase_items++;
          end
        end
      end
      calm = 1'b0;
      phase++;
    end

    // Let the last boundaries out, then give a late extra one time to show
    settle();

    if (mismatches == 0 && boundary_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
